/* design/ppe_pkg.sv */
// shared types, constants and helpers of the particle pool engine
package ppe_pkg;

	localparam int POOL_SIZE = 64;
	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 16;

	localparam logic [CFG_W-1:0] GRAVITY_RST = 16'd307;
	localparam logic [CFG_W-1:0] DRAG_RST = 16'd384;
	// 1.0 in Q.20
	localparam logic signed [33:0] DRAG_ONE = 34'sd1048576;
	localparam logic [7:0] ALPHA_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG = 1'd1;

	typedef enum logic [1:0] {
		ACT_SPAWN = 2'd0,
		ACT_STEP = 2'd1,
		ACT_RENDER = 2'd2
	} action_t;

	// one pool slot as held in the slot memory
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [15:0] life;
		logic [15:0] full;
		logic [15:0] size;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic [IDX_W-1:0] idx;
		logic rd;
		logic spawn_wr;
		logic setup;
		logic grav;
		logic dmul;
		logic dsat;
		logic pmul;
		logic wb;
		logic div_start;
		logic emit;
		logic emit_empty;
	} ppe_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic alive;
		logic any_alive;
		logic more_after;
		logic div_done;
	} ppe_sts_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

endpackage

/* design/particle_pool_engine_core.sv */
// particle pool engine top level: controller and datapath
// spawn: a scan of the alive map for the lowest free slot
// step: a setup state, then per live slot a check with one slot memory read, then grav,
// dmul, dsat, pmul and write back; render: a check per slot up to the top live one, and
// per live slot an alpha divider run, done at once at full life; results are registered
// reset clears the alive map and loads gravity 307 and drag 384; no clearing pass
module particle_pool_engine_core import ppe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             action,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	input  logic signed [31:0]     vel_x,
	input  logic signed [31:0]     vel_y,
	input  logic signed [31:0]     vel_z,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic [15:0]            duration,
	input  logic [15:0]            sprite_size,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   strobe,
	output logic                   valid_res,
	output logic signed [31:0]     out_pos_x,
	output logic signed [31:0]     out_pos_y,
	output logic signed [31:0]     out_pos_z,
	output logic [7:0]             out_red,
	output logic [7:0]             out_green,
	output logic [7:0]             out_blue,
	output logic [7:0]             alpha,
	output logic [15:0]            out_size,
	output logic                   last
);

	ppe_cmd_t cmd;
	ppe_sts_t sts;

	// sequencer
	ppe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.sts(sts),
		.busy(busy),
		.cmd(cmd)
	);

	// storage and arithmetic
	ppe_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.vel_z(vel_z),
		.red(red),
		.green(green),
		.blue(blue),
		.duration(duration),
		.sprite_size(sprite_size),
		.strobe(strobe),
		.valid_res(valid_res),
		.out_pos_x(out_pos_x),
		.out_pos_y(out_pos_y),
		.out_pos_z(out_pos_z),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.alpha(alpha),
		.out_size(out_size),
		.last(last)
	);

	// every result transfer belongs to an item in progress
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result outside an item");

	// the final result closes the render
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy) else $error("busy after final result");

	// an empty render is a single final item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !valid_res) |-> last) else $error("empty result not final");

endmodule

/* design/ppe_ram.sv */
// generic single write, single read ram with registered read
module ppe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/ppe_div.sv */
// iterative alpha divider, one quotient bit per cycle
module ppe_div import ppe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] life,
	input  logic [15:0] full,
	output logic        done,
	output logic [7:0]  quot
);

	logic [23:0] num;
	logic [16:0] trial;
	logic [15:0] rem_q;
	logic [7:0]  lo_q;
	logic [15:0] m_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [7:0]  quot_q;

	// rounded numerator life*255 + full/2
	assign num = {life, 8'h00} - {8'h00, life} + {9'h000, full[15:1]};
	assign trial = {rem_q, lo_q[7]};

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			if (life >= full) begin
				cnt_q <= '0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= 4'd8;
				done_q <= 1'b0;
			end
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				done_q <= 1'b1;
			end
		end
	end

	// restoring division, quotient known to fit eight bits
	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= full;
			rem_q <= num[23:8];
			lo_q <= num[7:0];
			quot_q <= (life >= full) ? ALPHA_MAX : 8'h00;
		end else if (cnt_q != '0) begin
			lo_q <= {lo_q[6:0], 1'b0};
			if (trial >= {1'b0, m_q}) begin
				rem_q <= 16'(trial - {1'b0, m_q});
				quot_q <= {quot_q[6:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quot_q <= {quot_q[6:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/ppe_ctrl.sv */
// controller state machine, walks the pool slots for each action
module ppe_ctrl import ppe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  ppe_sts_t   sts,
	output logic       busy,
	output ppe_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAWN,
		S_SETUP,
		S_STEP_CHK,
		S_GRAV,
		S_DMUL,
		S_DSAT,
		S_PMUL,
		S_WB,
		S_REN_BEGIN,
		S_REN_CHK,
		S_REN_DIV,
		S_REN_WAIT
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic busy_q;
	logic last_idx;

	assign last_idx = (idx_q == IDX_W'(POOL_SIZE - 1));

	// state, slot counter and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			busy_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (start) begin
						case (action)
							ACT_SPAWN: begin
								state_q <= S_SPAWN;
								busy_q <= 1'b1;
							end
							ACT_STEP: begin
								state_q <= S_SETUP;
								busy_q <= 1'b1;
							end
							ACT_RENDER: begin
								state_q <= S_REN_BEGIN;
								busy_q <= 1'b1;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SPAWN: begin
					if (!sts.alive || last_idx) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SETUP: state_q <= S_STEP_CHK;
				S_STEP_CHK: begin
					if (sts.alive) begin
						state_q <= S_GRAV;
					end else if (last_idx) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_GRAV: state_q <= S_DMUL;
				S_DMUL: state_q <= S_DSAT;
				S_DSAT: state_q <= S_PMUL;
				S_PMUL: state_q <= S_WB;
				S_WB: begin
					if (last_idx) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_STEP_CHK;
					end
				end
				S_REN_BEGIN: begin
					if (!sts.any_alive) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						state_q <= S_REN_CHK;
					end
				end
				S_REN_CHK: begin
					if (sts.alive) begin
						state_q <= S_REN_DIV;
					end else if (last_idx) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REN_DIV: state_q <= S_REN_WAIT;
				S_REN_WAIT: begin
					if (sts.div_done) begin
						if (!sts.more_after) begin
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_REN_CHK;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.load = (state_q == S_IDLE) && start;
		cmd.rd = ((state_q == S_STEP_CHK) || (state_q == S_REN_CHK)) && sts.alive;
		cmd.spawn_wr = (state_q == S_SPAWN) && !sts.alive;
		cmd.setup = (state_q == S_SETUP);
		cmd.grav = (state_q == S_GRAV);
		cmd.dmul = (state_q == S_DMUL);
		cmd.dsat = (state_q == S_DSAT);
		cmd.pmul = (state_q == S_PMUL);
		cmd.wb = (state_q == S_WB);
		cmd.div_start = (state_q == S_REN_DIV);
		cmd.emit = (state_q == S_REN_WAIT) && sts.div_done;
		cmd.emit_empty = (state_q == S_REN_BEGIN) && !sts.any_alive;
	end

	assign busy = busy_q;

	// a render result always comes from a live slot
	a_emit_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.alive) else $error("render result from a dead slot");

	// the step ends after the write back of the top slot
	a_step_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && last_idx) |=> !busy_q) else $error("step did not end");

	// the slot counter rests at zero while idle
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !busy_q) |=> (idx_q == '0))
		else $error("slot counter not cleared in idle");

endmodule

/* design/ppe_dp.sv */
// datapath: config, alive map, slot memory, euler lanes, render output
module ppe_dp import ppe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppe_cmd_t               cmd,
	output ppe_sts_t               sts,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	input  logic signed [31:0]     vel_x,
	input  logic signed [31:0]     vel_y,
	input  logic signed [31:0]     vel_z,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic [15:0]            duration,
	input  logic [15:0]            sprite_size,
	output logic                   strobe,
	output logic                   valid_res,
	output logic signed [31:0]     out_pos_x,
	output logic signed [31:0]     out_pos_y,
	output logic signed [31:0]     out_pos_z,
	output logic [7:0]             out_red,
	output logic [7:0]             out_green,
	output logic [7:0]             out_blue,
	output logic [7:0]             alpha,
	output logic [15:0]            out_size,
	output logic                   last
);

	logic [CFG_W-1:0] gravity_q;
	logic [CFG_W-1:0] drag_q;
	slot_t in_q;
	logic [15:0] dt_q;
	logic [31:0] gprod_q;
	logic [31:0] dprod_q;
	logic signed [33:0] factor_q;
	logic [POOL_SIZE-1:0] alive_q;
	logic [POOL_SIZE-1:0] above;
	logic [SLOT_W-1:0] rd_raw;
	slot_t rd_w;
	slot_t wb_w;
	slot_t wr_w;
	logic signed [31:0] v_s1 [3];
	logic signed [65:0] p_s2 [3];
	logic signed [31:0] v_s3 [3];
	logic signed [48:0] q_s4 [3];
	logic signed [33:0] vy_g;
	logic signed [31:0] pos_new [3];
	logic dies;
	logic div_done;
	logic [7:0] quot;
	logic strobe_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RST;
			drag_q <= DRAG_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GRAVITY: gravity_q <= cfg_data;
				CFG_DRAG: drag_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// capture of the input item and per tick products
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q.px <= pos_x;
			in_q.py <= pos_y;
			in_q.pz <= pos_z;
			in_q.vx <= vel_x;
			in_q.vy <= vel_y;
			in_q.vz <= vel_z;
			in_q.r <= red;
			in_q.g <= green;
			in_q.b <= blue;
			in_q.life <= duration;
			in_q.full <= duration;
			in_q.size <= sprite_size;
			dt_q <= duration;
			gprod_q <= gravity_q * duration;
			dprod_q <= drag_q * duration;
		end
		if (cmd.setup) begin
			factor_q <= DRAG_ONE - $signed({2'b00, dprod_q});
		end
	end

	// alive map
	assign dies = (rd_w.life <= dt_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (cmd.spawn_wr) begin
			alive_q[cmd.idx] <= 1'b1;
		end else if (cmd.wb && dies) begin
			alive_q[cmd.idx] <= 1'b0;
		end
	end

	// live slots above the current one
	always_comb begin
		for (int j = 0; j < POOL_SIZE; j++) begin
			above[j] = alive_q[j] && (IDX_W'(j) > cmd.idx);
		end
	end

	assign sts.alive = alive_q[cmd.idx];
	assign sts.any_alive = |alive_q;
	assign sts.more_after = |above;
	assign sts.div_done = div_done;

	// slot memory
	assign rd_w = rd_raw;
	assign wr_w = cmd.spawn_wr ? in_q : wb_w;

	ppe_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POOL_SIZE)
	) u_slots (
		.clk(clk),
		.wr_en(cmd.spawn_wr || cmd.wb),
		.wr_addr(cmd.idx),
		.wr_data(wr_w),
		.rd_en(cmd.rd),
		.rd_addr(cmd.idx),
		.rd_data(rd_raw)
	);

	// euler lanes, one per component
	assign vy_g = 34'(rd_w.vy) - $signed({6'b000000, gprod_q[31:4]});

	always_ff @(posedge clk) begin
		if (cmd.grav) begin
			v_s1[0] <= rd_w.vx;
			v_s1[1] <= sat32(66'(vy_g));
			v_s1[2] <= rd_w.vz;
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.dmul) begin
				p_s2[c] <= v_s1[c] * factor_q;
			end
			if (cmd.dsat) begin
				v_s3[c] <= sat32(p_s2[c] >>> 20);
			end
			if (cmd.pmul) begin
				q_s4[c] <= v_s3[c] * $signed({1'b0, dt_q});
			end
		end
	end

	// position update and write back word
	assign pos_new[0] = sat32(66'(50'(rd_w.px) + 50'(q_s4[0] >>> 12)));
	assign pos_new[1] = sat32(66'(50'(rd_w.py) + 50'(q_s4[1] >>> 12)));
	assign pos_new[2] = sat32(66'(50'(rd_w.pz) + 50'(q_s4[2] >>> 12)));

	always_comb begin
		wb_w = rd_w;
		wb_w.px = pos_new[0];
		wb_w.py = pos_new[1];
		wb_w.pz = pos_new[2];
		wb_w.vx = v_s3[0];
		wb_w.vy = v_s3[1];
		wb_w.vz = v_s3[2];
		wb_w.life = dies ? 16'h0000 : 16'(rd_w.life - dt_q);
	end

	// alpha from life ratio
	ppe_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.life(rd_w.life),
		.full(rd_w.full),
		.done(div_done),
		.quot(quot)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.emit_empty;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			valid_res <= 1'b1;
			out_pos_x <= rd_w.px;
			out_pos_y <= rd_w.py;
			out_pos_z <= rd_w.pz;
			out_red <= rd_w.r;
			out_green <= rd_w.g;
			out_blue <= rd_w.b;
			alpha <= quot;
			out_size <= rd_w.size;
			last <= !sts.more_after;
		end else if (cmd.emit_empty) begin
			valid_res <= 1'b0;
			out_pos_x <= '0;
			out_pos_y <= '0;
			out_pos_z <= '0;
			out_red <= '0;
			out_green <= '0;
			out_blue <= '0;
			alpha <= '0;
			out_size <= '0;
			last <= 1'b1;
		end
	end

	assign strobe = strobe_q;

endmodule
